// ----- hdl/cflvt_pkg.sv -----
// Package for the CAN frame last-value table: field widths, outcome codes,
// default depth and the table control struct.
// No dependencies.
package cflvt_pkg;

    localparam int ID_W     = 29;
    localparam int CTRL_W   = 6;
    localparam int DATA_W   = 64;
    localparam int SLOT_W   = 5;
    localparam int OUTC_W   = 2;
    localparam int ECNT_W   = 6;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic [OUTC_W-1:0] OUT_UPDATED  = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_INSERTED = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_DROPPED  = 2'd2;

    // Table access controls from the sequencer
    typedef struct packed {
        logic rd_en;   // read identifier memory
        logic id_we;   // write identifier
        logic rec_we;  // write control field and data
    } t_tbl_ctl;

endpackage

// ----- hdl/cflvt_in_if.sv -----
// Input channel interface: one received frame per transaction.
// Depends on cflvt_pkg.
interface cflvt_in_if;
    logic                          valid;
    logic                          ready;
    logic [cflvt_pkg::ID_W-1:0]    frame_id;
    logic [cflvt_pkg::CTRL_W-1:0]  control_bits;
    logic [cflvt_pkg::DATA_W-1:0]  payload;

    modport source (output valid, output frame_id, output control_bits, output payload,
                    input ready);
    modport sink   (input valid, input frame_id, input control_bits, input payload,
                    output ready);
endinterface

// ----- hdl/cflvt_out_if.sv -----
// Result channel interface: slot, outcome and entry count per transaction.
// Depends on cflvt_pkg.
interface cflvt_out_if;
    logic                          valid;
    logic                          ready;
    logic [cflvt_pkg::SLOT_W-1:0]  slot;
    logic [cflvt_pkg::OUTC_W-1:0]  outcome;
    logic [cflvt_pkg::ECNT_W-1:0]  entry_count;

    modport source (output valid, output slot, output outcome, output entry_count,
                    input ready);
    modport sink   (input valid, input slot, input outcome, input entry_count,
                    output ready);
endinterface

// ----- hdl/cflvt_table.sv -----
// Entry storage: identifier memory with registered read, record memory
// for control field and data. Depends on cflvt_pkg.
module cflvt_table #(
    parameter int TABLE_DEPTH = cflvt_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  cflvt_pkg::t_tbl_ctl           i_ctl,
    input  logic [IDX_W-1:0]              i_rd_addr,
    input  logic [IDX_W-1:0]              i_wr_addr,
    input  logic [cflvt_pkg::ID_W-1:0]    i_wr_id,
    input  logic [cflvt_pkg::CTRL_W-1:0]  i_wr_ctrl,
    input  logic [cflvt_pkg::DATA_W-1:0]  i_wr_data,
    output logic [cflvt_pkg::ID_W-1:0]    o_rd_id
);

    logic [cflvt_pkg::ID_W-1:0]   r_id_mem   [TABLE_DEPTH];
    logic [cflvt_pkg::CTRL_W-1:0] r_ctrl_mem [TABLE_DEPTH];
    logic [cflvt_pkg::DATA_W-1:0] r_data_mem [TABLE_DEPTH];
    logic [cflvt_pkg::ID_W-1:0]   r_rd_id;

    always_ff @(posedge i_clk) begin
        if (i_ctl.id_we) begin
            r_id_mem[i_wr_addr] <= i_wr_id;
        end
        if (i_ctl.rd_en) begin
            r_rd_id <= r_id_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rec_we) begin
            r_ctrl_mem[i_wr_addr] <= i_wr_ctrl;
            r_data_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_id = r_rd_id;

endmodule

// ----- hdl/can_frame_last_value_table.sv -----
// CAN frame last-value table, top level: sequencer, count and result register.
// One frame at a time, with a serial scan over the identifier memory read
// port; the next frame is taken while a result waits.
// Reset (synchronous, active low) clears the entry count and control; the
// memories are not cleared, only entries below the count are ever read.
module can_frame_last_value_table #(
    parameter int TABLE_DEPTH = cflvt_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cflvt_in_if.sink    i_in,
    cflvt_out_if.source o_out
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_XW = (IDX_W > cflvt_pkg::SLOT_W) ? IDX_W : cflvt_pkg::SLOT_W;
    localparam int CNT_XW  = (CNT_W > cflvt_pkg::ECNT_W) ? CNT_W : cflvt_pkg::ECNT_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } t_state;

    t_state                          r_state, n_state;

    // Held transaction
    logic [cflvt_pkg::ID_W-1:0]      r_key;
    logic [cflvt_pkg::CTRL_W-1:0]    r_ctrl;
    logic [cflvt_pkg::DATA_W-1:0]    r_data;

    // Scan pipeline: read issue index, compare stage index/valid
    logic [IDX_W-1:0]                r_rd_idx;
    logic [IDX_W-1:0]                r_cmp_idx;
    logic                            r_cmp_v;
    logic                            r_hit;
    logic [IDX_W-1:0]                r_slot;

    logic [CNT_W-1:0]                r_count;

    // Result register
    logic                            r_out_valid;
    logic [cflvt_pkg::SLOT_W-1:0]    r_out_slot;
    logic [cflvt_pkg::OUTC_W-1:0]    r_out_outcome;
    logic [cflvt_pkg::ECNT_W-1:0]    r_out_count;

    cflvt_pkg::t_tbl_ctl             tbl_ctl;
    logic [IDX_W-1:0]                wr_addr;
    logic [cflvt_pkg::ID_W-1:0]      rd_id;

    logic                            in_acc;
    logic                            out_free;
    logic                            cmp_match;
    logic                            cmp_last;
    logic                            room;
    logic                            commit;
    logic [IDX_W-1:0]                res_slot;
    logic [cflvt_pkg::OUTC_W-1:0]    res_outcome;
    logic [CNT_W-1:0]                res_count;
    logic [SLOT_XW-1:0]              slot_x;
    logic [CNT_XW-1:0]               cnt_x;

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign cmp_match = r_cmp_v && (rd_id == r_key);
    assign cmp_last  = r_cmp_v && ((CNT_W'(r_cmp_idx) + CNT_W'(1)) == r_count);
    assign room      = r_count < CNT_W'(TABLE_DEPTH);
    assign commit    = (r_state == ST_WRITE) && out_free;

    assign i_in.ready = (r_state == ST_IDLE);

    // Outcome of the held frame once the scan has finished
    always_comb begin
        priority if (r_hit) begin
            res_slot    = r_slot;
            res_outcome = cflvt_pkg::OUT_UPDATED;
            res_count   = r_count;
        end else if (room) begin
            res_slot    = IDX_W'(r_count);
            res_outcome = cflvt_pkg::OUT_INSERTED;
            res_count   = r_count + CNT_W'(1);
        end else begin
            res_slot    = '0;
            res_outcome = cflvt_pkg::OUT_DROPPED;
            res_count   = r_count;
        end
    end

    // Fields reported modulo their widths
    assign slot_x = SLOT_XW'(res_slot);
    assign cnt_x  = CNT_XW'(res_count);

    assign wr_addr        = res_slot;
    assign tbl_ctl.rd_en  = (r_state == ST_SCAN);
    assign tbl_ctl.id_we  = commit && !r_hit && room;
    assign tbl_ctl.rec_we = commit && (r_hit || room);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (r_count == '0) ? ST_WRITE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmp_match || cmp_last) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cmp_v     <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_cmp_v <= 1'b0;
                r_hit   <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_cmp_v <= !(cmp_match || cmp_last);
                if (cmp_match) begin
                    r_hit <= 1'b1;
                end
            end
            if (commit) begin
                r_count     <= res_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and index registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key    <= i_in.frame_id;
            r_ctrl   <= i_in.control_bits;
            r_data   <= i_in.payload;
            r_rd_idx <= '0;
        end else if (r_state == ST_SCAN) begin
            r_cmp_idx <= r_rd_idx;
            // hold at the last stored entry; surplus reads are discarded
            if ((CNT_W'(r_rd_idx) + CNT_W'(1)) < r_count) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if (cmp_match) begin
                r_slot <= r_cmp_idx;
            end
        end
        if (commit) begin
            r_out_slot    <= slot_x[cflvt_pkg::SLOT_W-1:0];
            r_out_outcome <= res_outcome;
            r_out_count   <= cnt_x[cflvt_pkg::ECNT_W-1:0];
        end
    end

    cflvt_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_ctl     (tbl_ctl),
        .i_rd_addr (r_rd_idx),
        .i_wr_addr (wr_addr),
        .i_wr_id   (r_key),
        .i_wr_ctrl (r_ctrl),
        .i_wr_data (r_data),
        .o_rd_id   (rd_id)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.slot        = r_out_slot;
    assign o_out.outcome     = r_out_outcome;
    assign o_out.entry_count = r_out_count;

endmodule

// ----- tb/can_frame_last_value_table_tb.sv -----
// Self-checking testbench for can_frame_last_value_table: a directed table of frames,
// then random frames, checked against typed rows or an identifier-table predictor.
// Depends on cflvt_pkg, cflvt_in_if, cflvt_out_if and the block itself.
module can_frame_last_value_table_tb;

    localparam int DEPTH        = cflvt_pkg::TABLE_DEPTH_DEF;
    localparam int ID_W         = cflvt_pkg::ID_W;
    localparam int CTRL_W       = cflvt_pkg::CTRL_W;
    localparam int DATA_W       = cflvt_pkg::DATA_W;
    localparam int SLOT_W       = cflvt_pkg::SLOT_W;
    localparam int OUTC_W       = cflvt_pkg::OUTC_W;
    localparam int ECNT_W       = cflvt_pkg::ECNT_W;
    localparam int DIRECTED_N   = 12;
    localparam int RANDOM_N     = 1300;
    localparam int TOTAL_N      = DIRECTED_N + RANDOM_N;
    // Worst gap between transactions is one full scan plus a rare run of
    // stalls; the first count also covers the reset cycles.
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = DEPTH + 8;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 800;
    localparam int IDLE_PCT     = 8;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CTRL_W-1:0] ctrl;
        logic [DATA_W-1:0] data;
    } t_frame;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [OUTC_W-1:0] outcome;
        logic [ECNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        t_frame  frame;
        logic    typed;    // expectation written in the row itself
        t_result result;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;

    cflvt_in_if  in_bus ();
    cflvt_out_if out_bus ();

    can_frame_last_value_table #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #2 clk = ~clk;

    t_stim_row stim_table [DIRECTED_N];

    // Identifiers held by the table, in insertion order. Control field and
    // data are never seen on the result port, so only the keys are kept.
    logic [ID_W-1:0] known_ids [DEPTH];
    int              known_count = 0;

    t_result expected_results [$];
    t_frame  frame_on_bus;
    logic    typed_on_bus;
    t_result typed_result;

    int frames_issued = 0;
    int frames_taken  = 0;
    int failures      = 0;
    int quiet_cycles  = 0;

    // Search in order, overwrite on a hit, append on a miss with room,
    // otherwise drop with slot zero and the count unchanged.
    function automatic t_result refresh_entry(t_frame f);
        t_result r;
        bit      found;
        found     = 1'b0;
        r.slot    = '0;
        r.outcome = cflvt_pkg::OUT_DROPPED;
        for (int k = 0; k < known_count; k++) begin
            if (!found && known_ids[k] == f.id) begin
                found     = 1'b1;
                r.slot    = SLOT_W'(k);
                r.outcome = cflvt_pkg::OUT_UPDATED;
            end
        end
        if (!found && known_count < DEPTH) begin
            r.slot                 = SLOT_W'(known_count);
            r.outcome              = cflvt_pkg::OUT_INSERTED;
            known_ids[known_count] = f.id;
            known_count++;
        end
        r.count = ECNT_W'(known_count);
        return r;
    endfunction

    function automatic bit calm_stretch();
        return frames_issued >= CALM_FIRST && frames_issued < CALM_LAST;
    endfunction

    task automatic report_mismatch(string what, t_result want, t_result got);
        failures++;
        if (failures <= REPORT_MAX) begin
            $display("%s: expected slot %0d outcome %0d count %0d,",
                     what, want.slot, want.outcome, want.count,
                     " got slot %0d outcome %0d count %0d",
                     got.slot, got.outcome, got.count);
        end
    endtask

    // Directed frames: key extremes, hits on both, alternating bit patterns,
    // a key one bit away from a stored one.
    initial begin
        stim_table[0]  = '{'{29'h0000000, 6'h00, 64'h0},
                           1'b1, '{5'd0, cflvt_pkg::OUT_INSERTED, 6'd1}};
        stim_table[1]  = '{'{29'h1FFFFFFF, 6'h3F, 64'hFFFF_FFFF_FFFF_FFFF},
                           1'b1, '{5'd1, cflvt_pkg::OUT_INSERTED, 6'd2}};
        stim_table[2]  = '{'{29'h0000000, 6'h3F, 64'hFFFF_FFFF_FFFF_FFFF},
                           1'b1, '{5'd0, cflvt_pkg::OUT_UPDATED, 6'd2}};
        stim_table[3]  = '{'{29'h1FFFFFFF, 6'h00, 64'h0},
                           1'b1, '{5'd1, cflvt_pkg::OUT_UPDATED, 6'd2}};
        stim_table[4]  = '{'{29'h15555555, 6'h2A, 64'hAAAA_AAAA_AAAA_AAAA},
                           1'b1, '{5'd2, cflvt_pkg::OUT_INSERTED, 6'd3}};
        stim_table[5]  = '{'{29'h0AAAAAAA, 6'h15, 64'h5555_5555_5555_5555},
                           1'b1, '{5'd3, cflvt_pkg::OUT_INSERTED, 6'd4}};
        stim_table[6]  = '{'{29'h1FFFFFFE, 6'h0F, 64'h0123_4567_89AB_CDEF},
                           1'b1, '{5'd4, cflvt_pkg::OUT_INSERTED, 6'd5}};
        stim_table[7]  = '{'{29'h0000001, 6'h08, 64'h8000_0000_0000_0000},
                           1'b1, '{5'd5, cflvt_pkg::OUT_INSERTED, 6'd6}};
        stim_table[8]  = '{'{29'h15555555, 6'h30, 64'h1},
                           1'b1, '{5'd2, cflvt_pkg::OUT_UPDATED, 6'd6}};
        stim_table[9]  = '{'{29'h0000001, 6'h1F, 64'hFF},
                           1'b1, '{5'd5, cflvt_pkg::OUT_UPDATED, 6'd6}};
        stim_table[10] = '{'{29'h10000000, 6'h20, 64'hFF00_0000_0000_0000},
                           1'b1, '{5'd6, cflvt_pkg::OUT_INSERTED, 6'd7}};
        stim_table[11] = '{'{29'h0000000, 6'h01, 64'h0000_0001_0000_0000},
                           1'b1, '{5'd0, cflvt_pkg::OUT_UPDATED, 6'd7}};
    end

    // Frame source: predicts on acceptance, then offers the next frame.
    always @(posedge clk) begin : feed
        t_frame  f;
        t_result want;
        int      pick;
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                want = refresh_entry(frame_on_bus);
                if (typed_on_bus)
                    want = typed_result;
                expected_results.push_back(want);
                frames_taken++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (frames_issued < TOTAL_N &&
                    (calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    typed_on_bus = 1'b0;
                    if (frames_issued < DIRECTED_N) begin
                        f            = stim_table[frames_issued].frame;
                        typed_on_bus = stim_table[frames_issued].typed;
                        typed_result = stim_table[frames_issued].result;
                    end else begin
                        // Fresh keys fill the table and later get dropped;
                        // stored keys give hits; near misses test the compare.
                        pick    = $urandom_range(0, 99);
                        f.id    = ID_W'($urandom);
                        f.ctrl  = CTRL_W'($urandom_range(0, 63));
                        f.data  = {$urandom, $urandom};
                        if (known_count > 0 && pick >= 40) begin
                            f.id = known_ids[$urandom_range(0, known_count - 1)];
                            if (pick < 50)
                                f.id = f.id ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
                        end
                    end
                    frame_on_bus        = f;
                    in_bus.valid        <= 1'b1;
                    in_bus.frame_id     <= f.id;
                    in_bus.control_bits <= f.ctrl;
                    in_bus.payload      <= f.data;
                    frames_issued++;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: compares each transaction with the oldest expectation.
    always @(posedge clk) begin : drain
        t_result got;
        t_result want;
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got = '{out_bus.slot, out_bus.outcome, out_bus.entry_count};
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none outstanding", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.slot !== want.slot || got.outcome !== want.outcome ||
                        got.count !== want.count)
                        report_mismatch("result mismatch", want, got);
                end
            end
            out_bus.ready <= calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        rst_n               = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.frame_id     = '0;
        in_bus.control_bits = '0;
        in_bus.payload      = '0;
        out_bus.ready       = 1'b0;
        typed_on_bus        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (frames_taken < TOTAL_N || expected_results.size() != 0)
            @(posedge clk);
        // Catch any stray result after the last expected one.
        repeat (SETTLE) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
